// ----- hdl/audwsh_pkg.sv -----
`default_nettype none
package audwsh_pkg;

    localparam int SAMPLE_BITS_DEF = 16;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MODE_W     = 2;
    localparam int DRIVE_W    = 16;
    localparam int SLOPE_W    = 12;
    localparam int CLIP_W     = 15;

    localparam logic [CFG_IDX_W-1:0] REG_SHAPE_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_AMOUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_SLOPE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEVEL   = 2'd3;

    localparam logic [MODE_W-1:0] MODE_SOFT_SAT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SOFT_CLIP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HARD_CLIP = 2'd2;

    localparam logic [MODE_W-1:0]  SHAPE_MODE_RST   = MODE_SOFT_CLIP;
    localparam logic [DRIVE_W-1:0] DRIVE_AMOUNT_RST = 16'd256;
    localparam logic [SLOPE_W-1:0] CURVE_SLOPE_RST  = 12'd512;
    localparam logic [CLIP_W-1:0]  CLIP_LEVEL_RST   = 15'd32767;

    // log / exp datapath
    localparam int POW_STEPS     = 16;
    localparam int LOG_FRAC_BITS = 16;
    localparam int SLOPE_FRAC    = 8;
    localparam int Q30_W         = 31;
    localparam logic [Q30_W-1:0] Q30_ONE = 31'h4000_0000;
    localparam int LG_W    = 21;
    localparam int TI_W    = 9;
    localparam int T_W     = TI_W + LOG_FRAC_BITS;
    localparam int PROD_W  = LG_W + SLOPE_W + 1;
    localparam int SH_W    = 10;

    function automatic logic [63:0] audwsh_isqrt(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        n = n_in;
        r = '0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (b > n)
            begin
                b = b >> 2;
            end
        end
        for (int i = 0; i < 32; i++)
        begin
            if (b != 64'd0)
            begin
                if (n >= r + b)
                begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // 2^(-2^-k) in Q1.30 by repeated floored square roots of one half
    function automatic logic [Q30_W-1:0] audwsh_coef(input int k);
        logic [63:0] c;
        c = 64'(Q30_ONE) >> 1;
        for (int j = 1; j <= k; j++)
        begin
            c = audwsh_isqrt(c << 30);
        end
        return c[Q30_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- hdl/audio_waveshaper_top.sv -----
`default_nettype none
// Waveshaper for a stream of signed Q1.F audio words (F = SAMPLE_BITS-1). Mode 0 gives
// x(1+a)/(1+a|x|^s) with |x|^s taken through a 16-step log2 by squaring and a 16-step
// exp2 by constant products; modes 1 and 3 give x(1+a)/(1+a|x|); mode 2 is mode 1 with
// the magnitude then limited to clip_level. Every mode runs the same fully pipelined
// path: one word is taken every cycle while the pipe is not frozen, the pipe depth being set
// by the two 16-stage log/exp chains and the restoring divider that resolves one quotient
// bit per stage. A held-off output freezes the pipe only while the stage ahead of the
// output register holds a word. Configuration must be written while no word is in
// flight; the config port is always ready.
module audio_waveshaper_top
    import audwsh_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output      logic                          in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
    output      logic                          out_valid,
    input  wire logic                          out_stall,
    output      logic signed [SAMPLE_BITS-1:0] sample_out,
    output      logic                          overflowed,
    input  wire logic                          cfg_valid,
    output      logic                          cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         cfg_data
);

    localparam int SB      = SAMPLE_BITS;
    localparam int FRAC    = SB - 1;
    localparam int EW      = $clog2(SB);
    localparam int NW      = SB + 17;
    localparam int RW      = SB + 16;
    localparam int QB      = SB + 8;
    localparam int SH_BASE = 31 - FRAC;
    localparam int CLIP_UP = (FRAC >= 15) ? FRAC - 15 : 0;
    localparam int CLIP_DN = (FRAC >= 15) ? 0 : 15 - FRAC;

    typedef struct packed {
        logic          neg;
        logic [SB-1:0] m;
        logic [NW-1:0] num;
        logic [EW-1:0] e;
    } side_t;

    // configuration registers
    logic [MODE_W-1:0]  shape_mode_reg;
    logic [DRIVE_W-1:0] drive_amount_reg;
    logic [SLOPE_W-1:0] curve_slope_reg;
    logic [CLIP_W-1:0]  clip_level_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_mode_reg   <= SHAPE_MODE_RST;
            drive_amount_reg <= DRIVE_AMOUNT_RST;
            curve_slope_reg  <= CURVE_SLOPE_RST;
            clip_level_reg   <= CLIP_LEVEL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SHAPE_MODE:   shape_mode_reg   <= cfg_data[MODE_W-1:0];
                REG_DRIVE_AMOUNT: drive_amount_reg <= cfg_data[DRIVE_W-1:0];
                REG_CURVE_SLOPE:  curve_slope_reg  <= cfg_data[SLOPE_W-1:0];
                REG_CLIP_LEVEL:   clip_level_reg   <= cfg_data[CLIP_W-1:0];
                default:          ;
            endcase
        end
    end

    // pipe advance
    logic adv;
    logic out_take;
    logic vr_reg;

    assign out_take = !out_valid || !out_stall;
    assign adv      = !vr_reg || out_take;
    assign in_stall = !adv;

    // input stage
    logic          v0_reg;
    logic [SB-1:0] x0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x0_reg <= sample_in;
        end
    end

    // sign and magnitude
    logic          v1_reg;
    logic          neg1_reg;
    logic [SB-1:0] m1_reg;
    logic [SB-1:0] m1_next;

    assign m1_next = x0_reg[SB-1] ? ('0 - x0_reg) : x0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg1_reg <= x0_reg[SB-1];
            m1_reg   <= m1_next;
        end
    end

    // leading one and numerator
    logic  v2_reg;
    side_t side2_reg;
    side_t side2_next;

    always_comb
    begin
        side2_next     = '0;
        side2_next.neg = neg1_reg;
        side2_next.m   = m1_reg;
        side2_next.num = NW'(m1_reg) * NW'({1'b0, drive_amount_reg} + 17'd256);
        for (int i = 0; i < SB; i++)
        begin
            if (m1_reg[i])
            begin
                side2_next.e = EW'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side2_reg <= side2_next;
        end
    end

    // log2 by repeated squaring; entry 0 holds the normalised magnitude
    logic                     sq_v_reg    [0:POW_STEPS];
    side_t                    sq_side_reg [0:POW_STEPS];
    logic [Q30_W-1:0]         sq_z_reg    [0:POW_STEPS];
    logic [LOG_FRAC_BITS-1:0] sq_f_reg    [0:POW_STEPS];
    logic [63:0]              z_wide;

    assign z_wide = (64'(side2_reg.m) << 30) >> side2_reg.e;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            sq_v_reg[0] <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_side_reg[0] <= side2_reg;
            sq_z_reg[0]    <= z_wide[Q30_W-1:0];
            sq_f_reg[0]    <= '0;
        end
    end

    for (genvar k = 1; k <= POW_STEPS; k++)
    begin : g_sq
        logic [61:0] sq_prod;
        logic [31:0] sq_top;

        assign sq_prod = 62'(sq_z_reg[k-1]) * 62'(sq_z_reg[k-1]);
        assign sq_top  = sq_prod[61:30];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                sq_v_reg[k] <= sq_v_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_side_reg[k] <= sq_side_reg[k-1];
                sq_z_reg[k]    <= sq_top[31] ? sq_top[31:1] : sq_top[30:0];
                sq_f_reg[k]    <= {sq_f_reg[k-1][LOG_FRAC_BITS-2:0], sq_top[31]};
            end
        end
    end

    // exponent t = -log2|x| * s; entry 0 of the exp chain
    logic                     ex_v_reg    [0:POW_STEPS];
    side_t                    ex_side_reg [0:POW_STEPS];
    logic [Q30_W-1:0]         ex_r_reg    [0:POW_STEPS];
    logic [TI_W-1:0]          ex_ti_reg   [0:POW_STEPS];
    logic [LOG_FRAC_BITS-1:0] ex_tf_reg   [0:POW_STEPS];
    logic [LG_W-1:0]          lg_next;
    logic [PROD_W-1:0]        t_prod;
    logic [T_W-1:0]           t_next;

    assign lg_next = ((LG_W'(FRAC) - LG_W'(sq_side_reg[POW_STEPS].e)) << LOG_FRAC_BITS)
                     - LG_W'(sq_f_reg[POW_STEPS]);
    assign t_prod  = PROD_W'(lg_next) * PROD_W'(curve_slope_reg)
                     + (PROD_W'(1) << (SLOPE_FRAC - 1));
    assign t_next  = t_prod[SLOPE_FRAC +: T_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            ex_v_reg[0] <= sq_v_reg[POW_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ex_side_reg[0] <= sq_side_reg[POW_STEPS];
            ex_r_reg[0]    <= Q30_ONE;
            ex_ti_reg[0]   <= t_next[T_W-1:LOG_FRAC_BITS];
            ex_tf_reg[0]   <= t_next[LOG_FRAC_BITS-1:0];
        end
    end

    // 2^-tf as a product of 2^(-2^-k) for each set fraction bit
    for (genvar k = 1; k <= POW_STEPS; k++)
    begin : g_ex
        localparam logic [Q30_W-1:0] CK = audwsh_coef(k);
        logic [61:0] ex_prod;
        logic        ex_bit;

        assign ex_prod = 62'(ex_r_reg[k-1]) * 62'(CK) + (62'(1) << 29);
        assign ex_bit  = ex_tf_reg[k-1][POW_STEPS-k];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ex_v_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                ex_v_reg[k] <= ex_v_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ex_side_reg[k] <= ex_side_reg[k-1];
                ex_r_reg[k]    <= ex_bit ? ex_prod[60:30] : ex_r_reg[k-1];
                ex_ti_reg[k]   <= ex_ti_reg[k-1];
                ex_tf_reg[k]   <= ex_tf_reg[k-1];
            end
        end
    end

    // power term for soft saturation, or the plain magnitude for every other mode
    logic          vp_reg;
    side_t         side_p_reg;
    logic [SB-1:0] p_reg;
    logic [SB-1:0] p_next;
    logic [SH_W-1:0] sh;
    logic [63:0]   pw_v;
    logic [63:0]   pw;

    assign sh   = SH_W'(SH_BASE) + SH_W'(ex_ti_reg[POW_STEPS]);
    assign pw_v = 64'(ex_r_reg[POW_STEPS]) << 1;

    always_comb
    begin
        if (sh >= SH_W'(63))
        begin
            pw = '0;
        end
        else if (sh == '0)
        begin
            pw = pw_v;
        end
        else
        begin
            pw = (pw_v + (64'd1 << (sh - SH_W'(1)))) >> sh;
        end

        if (shape_mode_reg != MODE_SOFT_SAT)
        begin
            p_next = ex_side_reg[POW_STEPS].m;
        end
        else if (ex_side_reg[POW_STEPS].m == '0)
        begin
            p_next = '0;
        end
        else
        begin
            p_next = pw[SB-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg <= 1'b0;
        end
        else if (adv)
        begin
            vp_reg <= ex_v_reg[POW_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_p_reg <= ex_side_reg[POW_STEPS];
            p_reg      <= p_next;
        end
    end

    // restoring divider, one quotient bit a stage; entry 0 holds the operands
    logic          dv_v_reg   [0:QB];
    logic          dv_neg_reg [0:QB];
    logic [RW-1:0] dv_rem_reg [0:QB];
    logic [RW-1:0] dv_den_reg [0:QB];
    logic [QB-1:0] dv_q_reg   [0:QB];
    logic [8:0]    dv_nb_reg  [0:QB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            dv_v_reg[0] <= vp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_neg_reg[0] <= side_p_reg.neg;
            dv_den_reg[0] <= (RW'(1) << (FRAC + 8)) + RW'(drive_amount_reg) * RW'(p_reg);
            dv_rem_reg[0] <= RW'(side_p_reg.num >> 9);
            dv_q_reg[0]   <= '0;
            dv_nb_reg[0]  <= side_p_reg.num[8:0];
        end
    end

    for (genvar j = 1; j <= QB; j++)
    begin : g_dv
        logic [RW:0] dv_t;
        logic        dv_ge;

        assign dv_t  = {dv_rem_reg[j-1], dv_nb_reg[j-1][8]};
        assign dv_ge = dv_t >= {1'b0, dv_den_reg[j-1]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[j] <= 1'b0;
            end
            else if (adv)
            begin
                dv_v_reg[j] <= dv_v_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_neg_reg[j] <= dv_neg_reg[j-1];
                dv_den_reg[j] <= dv_den_reg[j-1];
                dv_rem_reg[j] <= dv_ge ? RW'(dv_t - {1'b0, dv_den_reg[j-1]}) : RW'(dv_t);
                dv_q_reg[j]   <= {dv_q_reg[j-1][QB-2:0], dv_ge};
                dv_nb_reg[j]  <= {dv_nb_reg[j-1][7:0], 1'b0};
            end
        end
    end

    // round half up and saturate
    logic          negr_reg;
    logic          ovfr_reg;
    logic [SB-1:0] qr_reg;
    logic [QB:0]   q_rnd;
    logic [QB:0]   q_lim;
    logic          q_ovf;

    assign q_rnd = (QB + 1)'(dv_q_reg[QB])
                   + (QB + 1)'({dv_rem_reg[QB], 1'b0} >= {1'b0, dv_den_reg[QB]});
    assign q_lim = dv_neg_reg[QB] ? ((QB + 1)'(1) << FRAC)
                                  : (((QB + 1)'(1) << FRAC) - (QB + 1)'(1));
    assign q_ovf = q_rnd > q_lim;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vr_reg <= 1'b0;
        end
        else if (adv)
        begin
            vr_reg <= dv_v_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            negr_reg <= dv_neg_reg[QB];
            ovfr_reg <= q_ovf;
            qr_reg   <= q_ovf ? q_lim[SB-1:0] : q_rnd[SB-1:0];
        end
    end

    // hard clip, sign and output register
    logic          out_valid_reg;
    logic [SB-1:0] sample_out_reg;
    logic          overflowed_reg;
    logic [47:0]   clip_wide;
    logic [SB-1:0] clip_s;
    logic [SB-1:0] q_clip;
    logic [SB-1:0] res_next;

    assign clip_wide = (48'(clip_level_reg) << CLIP_UP) >> CLIP_DN;
    assign clip_s    = clip_wide[SB-1:0];
    assign q_clip    = (shape_mode_reg == MODE_HARD_CLIP && qr_reg > clip_s) ? clip_s : qr_reg;
    assign res_next  = negr_reg ? ('0 - q_clip) : q_clip;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            out_valid_reg <= vr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            sample_out_reg <= res_next;
            overflowed_reg <= ovfr_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign overflowed = overflowed_reg;

endmodule
`default_nettype wire

// ----- verif/audio_waveshaper_top_test.sv -----
`timescale 1ns / 100ps
`default_nettype none
module audio_waveshaper_top_test;
    import audwsh_pkg::*;

    localparam int SB = SAMPLE_BITS_DEF;
    localparam int FB = SB - 1;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int PIPE_DEPTH = 49 + SB;
    localparam longint CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic signed [SB-1:0] shaped;
        logic                 ovf;
    } shaped_word_t;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic signed [SB-1:0]         sample_in;
    logic                         out_valid;
    logic                         out_stall;
    logic signed [SB-1:0]         sample_out;
    logic                         overflowed;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index;
    logic [CFG_DATA_W-1:0]        cfg_data;

    // shadow copy of the registers
    logic [MODE_W-1:0]  mode_r;
    logic [DRIVE_W-1:0] drive_r;
    logic [SLOPE_W-1:0] slope_r;
    logic [CLIP_W-1:0]  clip_r;

    shaped_word_t shaped_q[$];
    longint unsigned exp_coef[1:16];
    int     err_count;
    int     send_idle_pct;
    int     stall_pct;
    int     hold_cycles;
    longint cycle_count;

    audio_waveshaper_top #(.SAMPLE_BITS(SB)) dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .overflowed (overflowed),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint unsigned floor_root(input longint unsigned n_in);
        longint unsigned n;
        longint unsigned r;
        longint unsigned b;
        n = n_in;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // |x|^s in Q.F via log2 by squaring and exp2 by constant products
    function automatic longint unsigned mag_power(input longint unsigned m,
                                                  input longint unsigned s);
        int e;
        longint unsigned z;
        longint unsigned f;
        longint unsigned lg;
        longint unsigned t;
        longint unsigned ti;
        longint unsigned tf;
        longint unsigned r;
        longint unsigned sh;
        e = 0;
        f = 0;
        if (m == 0)
            return 0;
        while (e < 63 && (m >> (e + 1)) != 0)
            e++;
        z = (e <= 30) ? (m << (30 - e)) : (m >> (e - 30));
        for (int i = 0; i < 16; i++)
        begin
            z = (z * z) >> 30;
            f = f << 1;
            if (z >= (64'd1 << 31))
            begin
                z = z >> 1;
                f = f | 1;
            end
        end
        if (e > FB)
            e = FB;
        lg = (longint'(FB - e) << 16) - f;
        t = (lg * s + 128) >> 8;
        ti = t >> 16;
        tf = t & 64'hFFFF;
        r = 64'd1 << 30;
        for (int k = 1; k <= 16; k++)
        begin
            if ((tf >> (16 - k)) & 1)
                r = (r * exp_coef[k] + (64'd1 << 29)) >> 30;
        end
        sh = (31 - FB) + ti;
        if (sh >= 63)
            return 0;
        if (sh == 0)
            return r << 1;
        return ((r << 1) + (64'd1 << (sh - 1))) >> sh;
    endfunction

    function automatic shaped_word_t shape_sample(input logic signed [SB-1:0] x);
        shaped_word_t w;
        logic neg;
        longint unsigned raw;
        longint unsigned m;
        longint unsigned one;
        longint unsigned p;
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        longint unsigned rem;
        longint unsigned lim;
        longint unsigned clip_s;
        raw = longint'($unsigned(x));
        neg = x[SB-1];
        one = 64'd1 << FB;
        m = neg ? ((64'd1 << SB) - raw) : raw;
        p = (mode_r == MODE_SOFT_SAT) ? mag_power(m, slope_r) : m;
        num = m * (256 + drive_r);
        den = (one << 8) + drive_r * p;
        q = (num << FB) / den;
        rem = (num << FB) % den;
        if ((rem << 1) >= den)
            q++;
        lim = neg ? one : one - 1;
        w.ovf = 1'b0;
        if (q > lim)
        begin
            q = lim;
            w.ovf = 1'b1;
        end
        if (mode_r == MODE_HARD_CLIP)
        begin
            clip_s = (FB >= 15) ? (longint'(clip_r) << (FB - 15))
                                : (longint'(clip_r) >> (15 - FB));
            if (q > clip_s)
                q = clip_s;
        end
        w.shaped = neg ? SB'((64'd1 << SB) - q) : SB'(q);
        return w;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SHAPE_MODE:   mode_r  = val[MODE_W-1:0];
            REG_DRIVE_AMOUNT: drive_r = val[DRIVE_W-1:0];
            REG_CURVE_SLOPE:  slope_r = val[SLOPE_W-1:0];
            REG_CLIP_LEVEL:   clip_r  = val[CLIP_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_sample(input logic signed [SB-1:0] x);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 12)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= x;
        do @(posedge clk); while (in_stall);
        shaped_q.push_back(shape_sample(x));
    endtask

    // lowers valid and waits until the pipe is empty
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        wait (shaped_q.size() == 0);
        repeat (PIPE_DEPTH + 8) @(posedge clk);
    endtask

    task automatic configure(input logic [MODE_W-1:0] md, input logic [DRIVE_W-1:0] dr,
                             input logic [SLOPE_W-1:0] sl, input logic [CLIP_W-1:0] cl);
        drain();
        write_reg(REG_SHAPE_MODE, CFG_DATA_W'(md));
        write_reg(REG_DRIVE_AMOUNT, dr);
        write_reg(REG_CURVE_SLOPE, CFG_DATA_W'(sl));
        write_reg(REG_CLIP_LEVEL, CFG_DATA_W'(cl));
    endtask

    function automatic logic signed [SB-1:0] pick_sample;
        case ($urandom_range(9))
            0: return SB'($urandom_range(3));
            1: return -SB'($urandom_range(3));
            2: return $urandom_range(1) ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
            3: return SB'($signed($urandom_range(511)) - 256);
            default: return SB'($urandom);
        endcase
    endfunction

    task automatic test_reset_defaults;
        send_idle_pct = 0;
        stall_pct = 0;
        send_sample(0);
        send_sample(SB'(32767));
        send_sample(SB'(-32768));
        send_sample(1);
        send_sample(-1);
        send_sample(SB'(16384));
    endtask

    task automatic test_directed_modes;
        // zero drive, full drive, zero slope, max slope, clip at zero, spare mode
        configure(MODE_SOFT_SAT, 16'd0, 12'd512, 15'd32767);
        send_sample(SB'(-32768));
        send_sample(SB'(12345));
        configure(MODE_SOFT_SAT, 16'hFFFF, 12'd0, 15'd0);
        send_sample(SB'(-32768));
        send_sample(SB'(32767));
        send_sample(0);
        configure(MODE_SOFT_SAT, 16'hFFFF, 12'hFFF, 15'd0);
        send_sample(1);
        send_sample(SB'(-20000));
        send_sample(SB'(32767));
        configure(MODE_HARD_CLIP, 16'hFFFF, 12'd512, 15'd0);
        send_sample(SB'(32767));
        send_sample(SB'(-32768));
        configure(MODE_HARD_CLIP, 16'd2560, 12'd512, 15'd16384);
        send_sample(SB'(30000));
        send_sample(SB'(-30000));
        send_sample(SB'(-32768));
        configure(MODE_SPARE, 16'd777, 12'd300, 15'h7FFF);
        send_sample(SB'(-32768));
        send_sample(SB'(9000));
        // upper data bits beyond the register width are dropped
        drain();
        write_reg(REG_SHAPE_MODE, 16'hFFFE);
        write_reg(REG_CURVE_SLOPE, 16'hF123);
        write_reg(REG_CLIP_LEVEL, 16'hC000);
        send_sample(SB'(-32768));
        send_sample(SB'(25000));
    endtask

    task automatic test_random_settings;
        logic [DRIVE_W-1:0] dr;
        logic [SLOPE_W-1:0] sl;
        logic [CLIP_W-1:0] cl;
        for (int set = 0; set < 12; set++)
        begin
            case ($urandom_range(3))
                0: dr = 16'hFFFF;
                1: dr = 16'($urandom_range(3));
                default: dr = 16'($urandom);
            endcase
            case ($urandom_range(3))
                0: sl = 12'hFFF;
                1: sl = 12'($urandom_range(1));
                default: sl = 12'($urandom);
            endcase
            cl = $urandom_range(3) == 0 ? 15'h7FFF : 15'($urandom);
            configure(MODE_W'(set % 4), dr, sl, cl);
            case (set % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 45; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 45; end
                default: begin send_idle_pct = 26; stall_pct = 26; end
            endcase
            for (int i = 0; i < 90; i++)
                send_sample(pick_sample());
        end
    endtask

    task automatic test_backpressure;
        configure(MODE_SOFT_SAT, 16'd1024, 12'd700, 15'd20000);
        send_idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 300;
        for (int i = 0; i < 150; i++)
            send_sample(pick_sample());
        // sender waits for the pipe to empty before carrying on
        in_valid <= 1'b0;
        @(posedge clk);
        wait (shaped_q.size() == 0);
        send_idle_pct = 26;
        stall_pct = 26;
        for (int i = 0; i < 60; i++)
            send_sample(pick_sample());
    endtask

    // result checker and output hold-off
    initial
    begin
        shaped_word_t want;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (shaped_q.size() == 0)
                begin
                    $error("unexpected word: sample_out %0d overflowed %0b", sample_out, overflowed);
                    err_count++;
                end
                else
                begin
                    want = shaped_q.pop_front();
                    if (sample_out !== want.shaped)
                    begin
                        $error("sample_out: expected %0d, got %0d", want.shaped, sample_out);
                        err_count++;
                    end
                    if (overflowed !== want.ovf)
                    begin
                        $error("overflowed: expected %0b, got %0b", want.ovf, overflowed);
                        err_count++;
                    end
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("audio_waveshaper_top_test: errors");
                $finish;
            end
        end
    end

    initial
    begin
        longint unsigned c;
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample_in = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        err_count = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        mode_r = SHAPE_MODE_RST;
        drive_r = DRIVE_AMOUNT_RST;
        slope_r = CURVE_SLOPE_RST;
        clip_r = CLIP_LEVEL_RST;
        c = 64'd1 << 29;
        for (int k = 1; k <= 16; k++)
        begin
            c = floor_root(c << 30);
            exp_coef[k] = c;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed_modes();
        test_random_settings();
        test_backpressure();

        drain();
        if (shaped_q.size() != 0)
            err_count++;
        if (err_count == 0)
            $display("audio_waveshaper_top_test: clean");
        else
            $display("audio_waveshaper_top_test: errors");
        $finish;
    end

endmodule
`default_nettype wire
